// ===== hdl/rbsi_pkg.sv =====
// shared constants and types for the ray box slab intersect unit
`default_nettype none
package rbsi_pkg;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned QW      = 32;
  localparam int unsigned QuoBits = 50;
  localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;
  localparam logic signed [QW-1:0] QMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic        neg;
    logic [48:0] rem;
    logic [49:0] quo;
    logic [31:0] dmag;
    logic        dzero;
  } div_lane_t;
endpackage
`default_nettype wire

// ===== hdl/ray_box_slab_intersect_unit.sv =====
// top level: pipelined slab test of a ray against an axis aligned box
// throughput: one request per cycle unless stalled; 50 cells per slab bound
// six dividers run side by side, one for each slab bound, one quotient bit per cell
// reset clears the stage valid bits only, payload registers are not reset
// a stalled output freezes the whole chain; no clearing pass after reset
`default_nettype none
module ray_box_slab_intersect_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] origin_x_i,
  input  wire logic [31:0] origin_y_i,
  input  wire logic [31:0] origin_z_i,
  input  wire logic [31:0] dir_x_i,
  input  wire logic [31:0] dir_y_i,
  input  wire logic [31:0] dir_z_i,
  input  wire logic [31:0] box_min_x_i,
  input  wire logic [31:0] box_min_y_i,
  input  wire logic [31:0] box_min_z_i,
  input  wire logic [31:0] box_max_x_i,
  input  wire logic [31:0] box_max_y_i,
  input  wire logic [31:0] box_max_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o,
  output logic [30:0]      hit_distance_o
);
  import rbsi_pkg::*;

  // input stage, cell chain, ordered pair, axis combine and output register
  localparam int unsigned NCells = QuoBits;
  localparam int unsigned Depth  = NCells + 4;

  // the whole pipe advances when the output slot is free or being drained
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  logic [31:0] org [NumAxes];
  logic [31:0] dir [NumAxes];
  logic [31:0] bmin [NumAxes];
  logic [31:0] bmax [NumAxes];
  assign org  = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir  = '{dir_x_i, dir_y_i, dir_z_i};
  assign bmin = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign bmax = '{box_max_x_i, box_max_y_i, box_max_z_i};

  // stage 0: differences, magnitudes, parallel-axis miss
  div_lane_t lane0_q [6];
  logic      pmiss_q [NumAxes];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NumAxes; a++) begin
        logic signed [32:0] dl, dh;
        logic [32:0] ml, mh;
        logic        dn;
        logic [31:0] dm;
        dl = {bmin[a][31], bmin[a]} - {org[a][31], org[a]};
        dh = {bmax[a][31], bmax[a]} - {org[a][31], org[a]};
        dn = dir[a][31];
        dm = dn ? (32'd0 - dir[a]) : dir[a];
        ml = dl[32] ? (33'd0 - dl) : dl;
        mh = dh[32] ? (33'd0 - dh) : dh;
        lane0_q[2*a]   <= '{neg: dl[32] ^ dn, rem: '0, quo: {1'b0, ml, 16'd0},
                            dmag: dm, dzero: (dir[a] == '0)};
        lane0_q[2*a+1] <= '{neg: dh[32] ^ dn, rem: '0, quo: {1'b0, mh, 16'd0},
                            dmag: dm, dzero: (dir[a] == '0)};
        pmiss_q[a] <= ($signed(org[a]) < $signed(bmin[a])) ||
                      ($signed(org[a]) > $signed(bmax[a]));
      end
    end
  end

  // chain of division cells, the parallel-miss flags ride alongside
  div_lane_t chain [6][NCells+1];
  logic [NumAxes-1:0] pm_q [NCells+1];
  assign pm_q[0] = {pmiss_q[2], pmiss_q[1], pmiss_q[0]};
  for (genvar l = 0; l < 6; l++) begin : g_lane
    assign chain[l][0] = lane0_q[l];
    for (genvar c = 0; c < NCells; c++) begin : g_cell
      rbsi_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .lane_i(chain[l][c]),
        .lane_o(chain[l][c+1])
      );
    end
  end
  for (genvar c = 0; c < NCells; c++) begin : g_pm
    always_ff @(posedge clk_i) begin
      if (adv) pm_q[c+1] <= pm_q[c];
    end
  end

  // saturate and sign the quotient (magnitude below 2^50)
  function automatic logic signed [31:0] sat_q(input logic neg, input logic [49:0] m);
    logic signed [31:0] r;
    if (neg) r = (m > 50'h8000_0000) ? QMin : $signed(32'd0 - m[31:0]);
    else     r = (m > 50'h7fff_ffff) ? QMax : $signed(m[31:0]);
    return r;
  endfunction

  // stage: ordered pair per axis
  logic signed [31:0] ta_q [NumAxes];
  logic signed [31:0] tb_q [NumAxes];
  logic [NumAxes-1:0] par_q, pmf_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NumAxes; a++) begin
        logic signed [31:0] x, y;
        x = sat_q(chain[2*a][NCells].neg, chain[2*a][NCells].quo);
        y = sat_q(chain[2*a+1][NCells].neg, chain[2*a+1][NCells].quo);
        ta_q[a]  <= (x > y) ? y : x;
        tb_q[a]  <= (x > y) ? x : y;
        par_q[a] <= chain[2*a][NCells].dzero;
      end
      pmf_q <= pm_q[NCells];
    end
  end

  // stage: combine axes in order, interval empty check after each non-parallel axis
  logic signed [31:0] tin_q, tout_q;
  logic               miss_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [31:0] ti, to;
      logic m;
      ti = QMin; to = QMax; m = 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        if (par_q[a]) begin
          if (pmf_q[a]) m = 1'b1;
        end else begin
          if (ta_q[a] > ti) ti = ta_q[a];
          if (tb_q[a] < to) to = tb_q[a];
          if (ti > to) m = 1'b1;
        end
      end
      tin_q <= ti; tout_q <= to; miss_q <= m;
    end
  end

  // output register
  logic        hit_q;
  logic [30:0] dist_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [31:0] th;
      logic h;
      th = tin_q[31] ? tout_q : tin_q;
      h  = !miss_q && !th[31];
      hit_q  <= h;
      dist_q <= h ? th[30:0] : '0;
    end
  end
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Depth-1];

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_q) && $stable(dist_q))
    else $error("result changed under stall");
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_distance_o == '0)
    else $error("miss with nonzero distance");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");
`endif
endmodule
`default_nettype wire

// ===== hdl/rbsi_div_cell.sv =====
// one restoring division step for one slab distance, holding its lane state
`default_nettype none
module rbsi_div_cell (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire rbsi_pkg::div_lane_t lane_i,
  output rbsi_pkg::div_lane_t      lane_o
);
  import rbsi_pkg::*;
  logic [49:0] trial;
  logic [48:0] rsh;
  logic        bit_in;
  div_lane_t   nxt;

  always_comb begin
    nxt    = lane_i;
    bit_in = lane_i.quo[QuoBits-1];
    rsh    = {lane_i.rem[47:0], bit_in};
    trial  = {1'b0, rsh} - {18'd0, lane_i.dmag};
    nxt.quo = {lane_i.quo[QuoBits-2:0], 1'b0};
    if (!trial[49]) begin
      nxt.rem    = trial[48:0];
      nxt.quo[0] = 1'b1;
    end else begin
      nxt.rem = rsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= nxt;
    end
  end
endmodule
`default_nettype wire

// ===== dv/ray_box_slab_intersect_unit_test.sv =====
// testbench for the ray box slab intersect unit: directed and random rays checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect_unit_test;
  typedef struct {
    logic [31:0] org [3];
    logic [31:0] dir [3];
    logic [31:0] lo [3];
    logic [31:0] hi [3];
  } ray_box_t;

  typedef struct {
    logic        hit;
    logic [30:0] distance;
  } hit_result_t;

  localparam int unsigned IdleLimit = 20000;
  localparam longint QHi = 64'sd2147483647;
  localparam longint QLo = -64'sd2147483648;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] origin_x_i, origin_y_i, origin_z_i;
  logic [31:0] dir_x_i, dir_y_i, dir_z_i;
  logic [31:0] box_min_x_i, box_min_y_i, box_min_z_i;
  logic [31:0] box_max_x_i, box_max_y_i, box_max_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [30:0] hit_distance_o;

  hit_result_t pending_hits[$];
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned hit_count;
  int unsigned checked_count;
  int unsigned idle_cycles;

  ray_box_slab_intersect_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // slab distance with truncating divide and saturation to q16.16
  function automatic longint slab_distance(longint bound, longint org, longint dir);
    longint q;
    q = ((bound - org) * 65536) / dir;
    if (q > QHi) q = QHi;
    if (q < QLo) q = QLo;
    return q;
  endfunction

  function automatic hit_result_t predict_hit(ray_box_t r);
    hit_result_t res;
    longint t_enter, t_exit, o, d, lo, hi, ta, tb, sw, t_hit;
    logic miss;
    t_enter = QLo;
    t_exit = QHi;
    miss = 1'b0;
    t_hit = 0;
    for (int ax = 0; ax < 3; ax++) begin
      o = longint'($signed(r.org[ax]));
      d = longint'($signed(r.dir[ax]));
      lo = longint'($signed(r.lo[ax]));
      hi = longint'($signed(r.hi[ax]));
      if (d == 0) begin
        if (o < lo || o > hi) miss = 1'b1;
      end else begin
        ta = slab_distance(lo, o, d);
        tb = slab_distance(hi, o, d);
        if (ta > tb) begin
          sw = ta;
          ta = tb;
          tb = sw;
        end
        if (ta > t_enter) t_enter = ta;
        if (tb < t_exit) t_exit = tb;
        if (t_enter > t_exit) miss = 1'b1;
      end
    end
    if (!miss) begin
      t_hit = (t_enter >= 0) ? t_enter : t_exit;
      if (t_hit < 0) miss = 1'b1;
    end
    res.hit = !miss;
    res.distance = miss ? 31'd0 : t_hit[30:0];
    return res;
  endfunction

  // one request, held until accepted, then a gap of the given length or back to back
  task automatic send_ray(ray_box_t r, int unsigned gap);
    origin_x_i <= r.org[0]; origin_y_i <= r.org[1]; origin_z_i <= r.org[2];
    dir_x_i <= r.dir[0]; dir_y_i <= r.dir[1]; dir_z_i <= r.dir[2];
    box_min_x_i <= r.lo[0]; box_min_y_i <= r.lo[1]; box_min_z_i <= r.lo[2];
    box_max_x_i <= r.hi[0]; box_max_y_i <= r.hi[1]; box_max_z_i <= r.hi[2];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_hits = {pending_hits, predict_hit(r)};
    sent_count++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  int unsigned burst_left;
  task automatic send_with_bursts(ray_box_t r);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
    send_ray(r, gap);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'(int'($urandom_range(0, 8)) - 4);
      4: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic ray_box_t unit_ray(int ax, logic [31:0] dir, logic [31:0] org);
    ray_box_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = 32'h0;
      r.dir[i] = 32'h0;
      r.lo[i] = 32'hffff_0000;
      r.hi[i] = 32'h0001_0000;
    end
    r.org[ax] = org;
    r.dir[ax] = dir;
    return r;
  endfunction

  task automatic test_directed();
    ray_box_t r;
    // ray from outside along each axis, both directions
    for (int ax = 0; ax < 3; ax++) begin
      send_ray(unit_ray(ax, 32'h0001_0000, 32'hfffb_0000), 0);
      send_ray(unit_ray(ax, 32'hffff_0000, 32'h0005_0000), 1);
    end
    // origin inside the box, entry negative so exit is chosen
    send_ray(unit_ray(0, 32'h0000_8000, 32'h0), 0);
    // box behind the ray
    send_ray(unit_ray(1, 32'hffff_0000, 32'hfffb_0000), 0);
    // parallel axis with origin outside its slab
    r = unit_ray(0, 32'h0001_0000, 32'hfffb_0000);
    r.org[2] = 32'h0002_0000;
    send_ray(r, 2);
    // inverted box on a parallel axis and on a moving axis
    r = unit_ray(0, 32'h0001_0000, 32'hfffb_0000);
    r.lo[1] = 32'h0001_0000; r.hi[1] = 32'hffff_0000;
    send_ray(r, 0);
    r = unit_ray(0, 32'h0001_0000, 32'hfffb_0000);
    r.lo[0] = 32'h0001_0000; r.hi[0] = 32'hffff_0000;
    send_ray(r, 0);
    // saturated distances from tiny directions and huge spans
    send_ray(unit_ray(2, 32'h0000_0001, 32'h8000_0000), 0);
    send_ray(unit_ray(2, 32'hffff_ffff, 32'h7fff_ffff), 0);
    // extreme field values everywhere
    for (int i = 0; i < 3; i++) begin
      r.org[i] = 32'h8000_0000; r.dir[i] = 32'h7fff_ffff;
      r.lo[i] = 32'h8000_0000; r.hi[i] = 32'h7fff_ffff;
    end
    send_ray(r, 0);
    for (int i = 0; i < 3; i++) begin
      r.org[i] = 32'h7fff_ffff; r.dir[i] = 32'h8000_0000;
    end
    send_ray(r, 0);
    // empty interval from disjoint axis ranges
    r = unit_ray(0, 32'h0001_0000, 32'hfffb_0000);
    r.dir[1] = 32'h0001_0000; r.org[1] = 32'h0014_0000;
    send_ray(r, 3);
    // all-zero request
    for (int i = 0; i < 3; i++) begin
      r.org[i] = 0; r.dir[i] = 0; r.lo[i] = 0; r.hi[i] = 0;
    end
    send_ray(r, 0);
  endtask

  task automatic test_random_rays(int unsigned count);
    ray_box_t r;
    logic [31:0] a, b, c;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        // well-formed box around a random center, ray aimed roughly at it
        for (int i = 0; i < 3; i++) begin
          c = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
          a = 32'($urandom_range(1, 32'h003f_ffff));
          r.lo[i] = c - a;
          r.hi[i] = c + a;
          b = 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
          r.org[i] = c + b;
          r.dir[i] = ($urandom_range(0, 7) == 0) ? 32'h0 : -b + 32'($urandom_range(0, 32'h7_ffff));
          if ($urandom_range(0, 5) == 0) r.dir[i] = r.dir[i] >>> $urandom_range(4, 20);
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          r.org[i] = rand_word(); r.dir[i] = rand_word();
          r.lo[i] = rand_word(); r.hi[i] = rand_word();
        end
      end
      send_with_bursts(r);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // receiver stall pattern: alternating free and jammed stretches
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      case ($urandom_range(0, 3))
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= out_stall_i;
      endcase
      if ($urandom_range(0, 200) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 150)) @(negedge clk_i);
      end
    end
  end

  // result checker against the oldest pending prediction
  always @(posedge clk_i) begin
    hit_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0d dist=%h", hit_o, hit_distance_o);
      end else begin
        exp_res = pending_hits.pop_front();
        checked_count++;
        if (exp_res.hit) hit_count++;
        if (hit_o !== exp_res.hit || hit_distance_o !== exp_res.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected hit=%0d dist=%h, got hit=%0d dist=%h",
                     checked_count, exp_res.hit, exp_res.distance, hit_o, hit_distance_o);
        end
      end
    end
  end

  // watchdog on cycles with no accepted request or result while results are pending
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || pending_hits.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results pending", pending_hits.size());
      $display("ray_box_slab_intersect_unit_test failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0; sent_count = 0; hit_count = 0; checked_count = 0;
    idle_cycles = 0; burst_left = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0;
    origin_x_i = 0; origin_y_i = 0; origin_z_i = 0;
    dir_x_i = 0; dir_y_i = 0; dir_z_i = 0;
    box_min_x_i = 0; box_min_y_i = 0; box_min_z_i = 0;
    box_max_x_i = 0; box_max_y_i = 0; box_max_z_i = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_rays(1950);
    wait_drain();
    if (pending_hits.size() != 0) mismatches++;
    $display("sent %0d ray/box requests, checked %0d results, %0d of them hits",
             sent_count, checked_count, hit_count);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("ray_box_slab_intersect_unit_test passed");
    else
      $display("ray_box_slab_intersect_unit_test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/rbsi_pkg.sv
hdl/rbsi_div_cell.sv
hdl/ray_box_slab_intersect_unit.sv
dv/ray_box_slab_intersect_unit_test.sv
